// File: hw/rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared constants, register indexes and types of the masked signature
// scanner.
// ----------------------------------------------------------------------------
package mss_pkg;

    // Default parameter values
    localparam int unsigned MAX_PATTERN_DEFAULT   = 16;
    localparam int unsigned ADDRESS_WIDTH_DEFAULT = 32;

    // Pattern storage: sixteen configured bytes
    localparam int unsigned PATTERN_BYTES = 16'h10;
    localparam int unsigned PAT_IDX_W     = 4;

    // Effective length width, covers every length up to the largest window
    localparam int unsigned LEN_W = 7;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALIGN_EN     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALIGN_SHIFT  = 3'd5;

    // Register reset values
    localparam logic [15:0] CARE_MASK_RESET   = 16'hFFFF;
    localparam logic [4:0]  PATTERN_LEN_RESET = 5'd1;
    localparam logic        ALIGN_EN_RESET    = 1'b1;
    localparam logic [3:0]  ALIGN_SHIFT_RESET = 4'd4;

    // Result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue
    localparam int unsigned RES_FIFO_DEPTH = 4;
    localparam int unsigned RES_PTR_W      = 2;
    localparam int unsigned RES_CNT_W      = 3;

    // Pattern settings seen by every cell
    typedef struct packed {
        logic [8*PATTERN_BYTES-1:0] pattern;
        logic [PATTERN_BYTES-1:0]   care;
        logic [LEN_W-1:0]           eff_len;
    } cell_cfg_t;

endpackage

// File: hw/rtl/mss_cell.sv
// ----------------------------------------------------------------------------
// mss_cell
// One window cell: compares the byte shifting into it against the pattern
// byte that lines up with its place, then stores it for the next cell.
// ----------------------------------------------------------------------------
module mss_cell #(
    parameter int unsigned CELL_INDEX = 0
) (
    input  logic               aclk,
    input  logic               shift_en,
    input  mss_pkg::cell_cfg_t cfg,
    input  logic [7:0]         byte_in,
    input  logic               excl_in,
    output logic [7:0]         byte_out,
    output logic               excl_out,
    output logic               hit,
    output logic               start_excl
);

    localparam logic [mss_pkg::LEN_W-1:0] IDX = mss_pkg::LEN_W'(CELL_INDEX);

    logic [7:0]                    byte_reg;
    logic                          excl_reg;
    logic                          in_use;
    logic [mss_pkg::LEN_W-1:0]     pat_pos;
    logic                          in_pat;
    logic [mss_pkg::PAT_IDX_W-1:0] pat_sel;
    logic [7:0]                    pat_byte;
    logic                          care;

    // Locate the pattern byte that faces this cell
    always_comb begin
        in_use   = IDX < cfg.eff_len;
        pat_pos  = cfg.eff_len - mss_pkg::LEN_W'(1) - IDX;
        in_pat   = pat_pos < mss_pkg::LEN_W'(mss_pkg::PATTERN_BYTES);
        pat_sel  = pat_pos[mss_pkg::PAT_IDX_W-1:0];
        pat_byte = cfg.pattern[{pat_sel, 3'b000} +: 8];
        care     = in_pat && cfg.care[pat_sel];
    end

    // Masked compare of the incoming byte
    assign hit        = !in_use || !care || (byte_in == pat_byte);
    assign start_excl = in_use && (pat_pos == '0) && excl_in;

    // Advance the window
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
            excl_reg <= excl_in;
        end
    end

    assign byte_out = byte_reg;
    assign excl_out = excl_reg;

endmodule

// File: hw/rtl/mss_result_fifo.sv
// ----------------------------------------------------------------------------
// mss_result_fifo
// Small result queue that takes up to two results per cycle and hands out
// one per transaction.
// ----------------------------------------------------------------------------
module mss_result_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [1:0]                     push_cnt,
    input  logic [WIDTH-1:0]               push0_data,
    input  logic [WIDTH-1:0]               push1_data,
    input  logic                           pop,
    output logic [WIDTH-1:0]               head_data,
    output logic                           not_empty,
    output logic [mss_pkg::RES_CNT_W-1:0]  count
);

    logic [WIDTH-1:0]              mem [mss_pkg::RES_FIFO_DEPTH];
    logic [mss_pkg::RES_PTR_W-1:0] wptr_reg, wptr_next;
    logic [mss_pkg::RES_PTR_W-1:0] rptr_reg, rptr_next;
    logic [mss_pkg::RES_CNT_W-1:0] count_reg, count_next;
    logic                          do_pop;

    assign do_pop = pop && (count_reg != '0);

    // Pointer and fill bookkeeping
    always_comb begin
        wptr_next  = wptr_reg + mss_pkg::RES_PTR_W'(push_cnt);
        rptr_next  = rptr_reg + mss_pkg::RES_PTR_W'(do_pop);
        count_next = count_reg + mss_pkg::RES_CNT_W'(push_cnt)
                     - mss_pkg::RES_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store results in order
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wptr_reg] <= push0_data;
        end
        if (push_cnt == 2'd2) begin
            mem[wptr_reg + mss_pkg::RES_PTR_W'(1)] <= push1_data;
        end
    end

    assign head_data = mem[rptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

    // Fill level never passes the depth
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mss_pkg::RES_CNT_W'(mss_pkg::RES_FIFO_DEPTH))
        else $error("result queue overflow");

endmodule

// File: hw/rtl/masked_signature_scanner_core.sv
// ----------------------------------------------------------------------------
// masked_signature_scanner_core
// Streaming search of a masked byte pattern over a run of memory bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one memory byte per transaction with its
//   address; tuser flags a byte where no match may start, tlast marks the
//   final byte of the scanned region. Output stream m_axis carries match
//   reports (tuser = 0, start address) and one end-of-scan summary per
//   region (tuser = 1, match count and any-match flag); tlast marks the
//   final result caused by one input byte.
//   The pattern registers are written through cfg_wr_en / cfg_index /
//   cfg_wdata while no scan is in flight.
//   Throughput: one byte per cycle. The window is a row of MAX_PATTERN cells
//   that each compare one byte as it shifts in; the match decision sits in
//   a second stage registered after the cells, and its results enter the result queue.
//   A four-entry result queue decouples the output: when the receiver
//   stalls, the queue fills and s_axis_tready drops once fewer than two
//   entries are free, then the input holds until the queue drains.
//   Reset (aresetn low, synchronous) restores the register defaults and
//   starts a fresh scan; an end-of-scan byte also starts a fresh scan.
// ----------------------------------------------------------------------------
module masked_signature_scanner_core #(
    parameter int unsigned MAX_PATTERN   = mss_pkg::MAX_PATTERN_DEFAULT,
    parameter int unsigned ADDRESS_WIDTH = mss_pkg::ADDRESS_WIDTH_DEFAULT,
    localparam int unsigned IN_TDATA_W   = ((ADDRESS_WIDTH + 8 + 7) / 8) * 8,
    localparam int unsigned OUT_TDATA_W  = ((ADDRESS_WIDTH + 33 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration writes
    input  logic                            cfg_wr_en,
    input  logic [mss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_TDATA_W-1:0]           s_axis_tdata,  // address, data_byte
    input  logic                            s_axis_tuser,  // excluded_start
    input  logic                            s_axis_tlast,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_TDATA_W-1:0]          m_axis_tdata,  // match_address, match_count, any_match
    output logic                            m_axis_tuser,  // kind
    output logic                            m_axis_tlast
);

    localparam int unsigned AW     = ADDRESS_WIDTH;
    localparam int unsigned SEEN_W = $clog2(MAX_PATTERN + 1);
    localparam int unsigned RES_W  = OUT_TDATA_W + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [15:0] care_mask_reg;
    logic [4:0]  pattern_len_reg;
    logic        align_en_reg;
    logic [3:0]  align_shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= mss_pkg::CARE_MASK_RESET;
            pattern_len_reg  <= mss_pkg::PATTERN_LEN_RESET;
            align_en_reg     <= mss_pkg::ALIGN_EN_RESET;
            align_shift_reg  <= mss_pkg::ALIGN_SHIFT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mss_pkg::CFG_PATTERN_LOW:  pattern_low_reg  <= cfg_wdata;
                mss_pkg::CFG_PATTERN_HIGH: pattern_high_reg <= cfg_wdata;
                mss_pkg::CFG_CARE_MASK:    care_mask_reg    <= cfg_wdata[15:0];
                mss_pkg::CFG_PATTERN_LEN:  pattern_len_reg  <= cfg_wdata[4:0];
                mss_pkg::CFG_ALIGN_EN:     align_en_reg     <= cfg_wdata[0];
                mss_pkg::CFG_ALIGN_SHIFT:  align_shift_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Clamp the length into 1..MAX_PATTERN
    logic [mss_pkg::LEN_W-1:0] len_ext;
    logic [mss_pkg::LEN_W-1:0] eff_len;

    always_comb begin
        len_ext = mss_pkg::LEN_W'(pattern_len_reg);
        priority if (len_ext == '0) begin
            eff_len = mss_pkg::LEN_W'(1);
        end else if (len_ext > mss_pkg::LEN_W'(MAX_PATTERN)) begin
            eff_len = mss_pkg::LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = len_ext;
        end
    end

    mss_pkg::cell_cfg_t cell_cfg;

    assign cell_cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cell_cfg.care    = care_mask_reg;
    assign cell_cfg.eff_len = eff_len;

    // ------------------------------------------------------------------
    // Input transaction and window cells
    // ------------------------------------------------------------------
    logic          s_accept;
    logic [AW-1:0] in_address;
    logic [7:0]    in_byte;

    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign in_address = s_axis_tdata[AW-1:0];
    assign in_byte    = s_axis_tdata[AW+7:AW];

    logic [7:0]             chain_byte [MAX_PATTERN+1];
    logic                   chain_excl [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] cell_hit;
    logic [MAX_PATTERN-1:0] cell_start_excl;

    assign chain_byte[0] = in_byte;
    assign chain_excl[0] = s_axis_tuser;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        mss_cell #(
            .CELL_INDEX(j)
        ) u_cell (
            .aclk      (aclk),
            .shift_en  (s_accept),
            .cfg       (cell_cfg),
            .byte_in   (chain_byte[j]),
            .excl_in   (chain_excl[j]),
            .byte_out  (chain_byte[j+1]),
            .excl_out  (chain_excl[j+1]),
            .hit       (cell_hit[j]),
            .start_excl(cell_start_excl[j])
        );
    end

    // Fill count of the window, cleared after the final byte
    logic [SEEN_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic              seen_ok;

    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        if (bytes_seen_reg < SEEN_W'(MAX_PATTERN)) begin
            bytes_seen_next = bytes_seen_reg + SEEN_W'(1);
        end
        seen_ok = mss_pkg::LEN_W'(bytes_seen_next) >= eff_len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= '0;
        end else if (s_accept) begin
            bytes_seen_reg <= s_axis_tlast ? '0 : bytes_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Compare stage register
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic          s1_try_reg;
    logic          s1_last_reg;
    logic [AW-1:0] s1_cand_reg;
    logic          s1_fire;
    logic [mss_pkg::RES_CNT_W-1:0] fifo_count;

    assign s1_fire       = s1_valid_reg &&
                           (fifo_count <= mss_pkg::RES_CNT_W'(mss_pkg::RES_FIFO_DEPTH - 2));
    assign s_axis_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_try_reg  <= seen_ok && (&cell_hit) && !(|cell_start_excl);
            s1_last_reg <= s_axis_tlast;
            s1_cand_reg <= in_address - AW'(eff_len - mss_pkg::LEN_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Decision stage: skip point, alignment, count
    // ------------------------------------------------------------------
    logic          skip_active_reg;
    logic [AW-1:0] next_allowed_reg;
    logic [31:0]   matches_found_reg;
    logic [AW-1:0] align_mask;
    logic          before_skip;
    logic          align_bad;
    logic          take_match;
    logic [31:0]   count_inc;
    logic [31:0]   count_after;

    always_comb begin
        align_mask  = ~({AW{1'b1}} << align_shift_reg);
        before_skip = skip_active_reg && (s1_cand_reg < next_allowed_reg);
        align_bad   = align_en_reg && (matches_found_reg == '0) &&
                      ((s1_cand_reg & align_mask) != '0);
        take_match  = s1_try_reg && !before_skip && !align_bad;
        count_inc   = (matches_found_reg == '1) ? matches_found_reg
                                                : matches_found_reg + 32'd1;
        count_after = take_match ? count_inc : matches_found_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_active_reg   <= 1'b0;
            next_allowed_reg  <= '0;
            matches_found_reg <= '0;
        end else if (s1_fire) begin
            if (s1_last_reg) begin
                skip_active_reg   <= 1'b0;
                next_allowed_reg  <= '0;
                matches_found_reg <= '0;
            end else if (take_match) begin
                skip_active_reg   <= 1'b1;
                next_allowed_reg  <= s1_cand_reg + AW'(eff_len) + AW'(1);
                matches_found_reg <= count_inc;
            end
        end
    end

    // Build result records: {kind, last, tdata}
    logic [OUT_TDATA_W-1:0] match_tdata;
    logic [OUT_TDATA_W-1:0] summary_tdata;
    logic [RES_W-1:0]       match_rec;
    logic [RES_W-1:0]       summary_rec;
    logic [1:0]             push_cnt;
    logic [RES_W-1:0]       push0_data;

    always_comb begin
        match_tdata                   = '0;
        match_tdata[AW-1:0]           = s1_cand_reg;
        match_tdata[AW+31:AW]         = count_inc;
        match_tdata[AW+32]            = 1'b1;
        summary_tdata                 = '0;
        summary_tdata[AW+31:AW]       = count_after;
        summary_tdata[AW+32]          = count_after != '0;
        match_rec   = {mss_pkg::KIND_MATCH, !s1_last_reg, match_tdata};
        summary_rec = {mss_pkg::KIND_SUMMARY, 1'b1, summary_tdata};
        push_cnt    = '0;
        if (s1_fire) begin
            push_cnt = 2'(take_match) + 2'(s1_last_reg);
        end
        push0_data  = take_match ? match_rec : summary_rec;
    end

    // ------------------------------------------------------------------
    // Result queue and output stream
    // ------------------------------------------------------------------
    logic [RES_W-1:0] head_data;

    mss_result_fifo #(
        .WIDTH(RES_W)
    ) u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0_data(push0_data),
        .push1_data(summary_rec),
        .pop       (m_axis_tready),
        .head_data (head_data),
        .not_empty (m_axis_tvalid),
        .count     (fifo_count)
    );

    assign m_axis_tdata = head_data[OUT_TDATA_W-1:0];
    assign m_axis_tlast = head_data[OUT_TDATA_W];
    assign m_axis_tuser = head_data[OUT_TDATA_W+1];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skip_needs_match: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_active_reg |-> (matches_found_reg != '0))
        else $error("skip point set without a recorded match");

    a_last_clears_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_axis_tlast) |=> (bytes_seen_reg == '0))
        else $error("window fill count not cleared after final byte");

    a_summary_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == mss_pkg::KIND_SUMMARY)) |-> m_axis_tlast)
        else $error("summary not marked as final result");

endmodule
